// File: sv/geiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geiq_pkg
// Types and constants shared by the GPIO edge interrupt qualifier.
// ----------------------------------------------------------------------------
package geiq_pkg;

  localparam int PIN_W    = 8;
  localparam int MASK_W   = 32;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;
  localparam int FPIN_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_ENABLE_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISING_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLING_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd4;

  typedef struct packed {
    logic [PIN_W-1:0]  pin_number;
    logic              new_level;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic              fire;
    logic [FPIN_W-1:0] fired_pin;
    logic              edge_kind;
  } out_item_t;

  typedef struct packed {
    logic              global_enable;
    logic [MASK_W-1:0] pin_enable_mask;
    logic [MASK_W-1:0] rising_mask;
    logic [MASK_W-1:0] falling_mask;
    logic [DEB_W-1:0]  debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic              candidate;
    logic              both;
    logic [FPIN_W-1:0] pin;
    logic              level;
    logic [TIME_W-1:0] time_ms;
  } cls_item_t;

endpackage

// File: sv/geiq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geiq_queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module geiq_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: sv/geiq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geiq_front
// Classify an event against enables and edge masks.
// ----------------------------------------------------------------------------
module geiq_front #(
  parameter int TABLE_DEPTH = 32
) (
  input  geiq_pkg::cfg_t      cfg,
  input  geiq_pkg::in_item_t  evt,
  output geiq_pkg::cls_item_t cls
);

  localparam logic [geiq_pkg::PIN_W-1:0] PIN_LIMIT = geiq_pkg::PIN_W'(TABLE_DEPTH);

  logic [geiq_pkg::FPIN_W-1:0] pin_lo;
  logic in_range;
  logic rise;
  logic fall;
  logic en;
  logic accept;

  always_comb begin
    pin_lo   = evt.pin_number[geiq_pkg::FPIN_W-1:0];
    in_range = (evt.pin_number < PIN_LIMIT);
    rise     = cfg.rising_mask[pin_lo];
    fall     = cfg.falling_mask[pin_lo];
    en       = cfg.pin_enable_mask[pin_lo];
    accept   = evt.new_level ? rise : fall;

    cls.candidate = cfg.global_enable && in_range && en && accept;
    cls.both      = rise && fall;
    cls.pin       = pin_lo;
    cls.level     = evt.new_level;
    cls.time_ms   = evt.time_ms;
  end

endmodule

// File: sv/geiq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geiq_back
// Apply both-edges and debounce checks against per-pin state; update state.
// ----------------------------------------------------------------------------
module geiq_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [geiq_pkg::DEB_W-1:0] debounce_ms,
  input  geiq_pkg::cls_item_t  cls,
  output geiq_pkg::out_item_t  res
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [geiq_pkg::TIME_W-1:0] last_event_time  [TABLE_DEPTH];
  logic                        last_fired_level [TABLE_DEPTH];

  logic [IW-1:0]               idx;
  logic                        want;
  logic                        deb_on;
  logic [geiq_pkg::TIME_W-1:0] diff;
  logic                        too_soon;
  logic                        fire;

  always_comb begin
    idx      = cls.pin[IW-1:0];
    want     = cls.candidate && (!cls.both || (cls.level != last_fired_level[idx]));
    deb_on   = (debounce_ms != '0);
    diff     = cls.time_ms - last_event_time[idx];
    too_soon = deb_on && (diff < {{(geiq_pkg::TIME_W - geiq_pkg::DEB_W){1'b0}}, debounce_ms});
    fire     = want && !too_soon;

    res.fire      = fire;
    res.fired_pin = cls.pin;
    res.edge_kind = cls.level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        last_event_time[i]  <= '0;
        last_fired_level[i] <= 1'b0;
      end
    end else if (go) begin
      if (want && deb_on) begin
        last_event_time[idx] <= cls.time_ms;
      end
      if (fire && cls.both) begin
        last_fired_level[idx] <= cls.level;
      end
    end
  end

endmodule

// File: sv/gpio_edge_irq_qualifier.sv
`timescale 1ns / 1ps
// An accepted item is held in the middle queue, then passes the back stage, which
// applies the per-pin state update, into the output queue that drives the result ports.
// Throughput: one item per cycle when not stalled by a full output queue.
// Reset clears both queues, the per-pin time and level tables and the
// configuration (global enable set, masks and debounce zero); no clearing pass.
// ----------------------------------------------------------------------------
// gpio_edge_irq_qualifier
// Qualifies GPIO pin-change events into interrupt decisions with debounce.
// ----------------------------------------------------------------------------
module gpio_edge_irq_qualifier #(
  parameter int PIN_COUNT = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  geiq_pkg::in_item_t                  evt,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output geiq_pkg::out_item_t                 res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [geiq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [geiq_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int TABLE_DEPTH = (PIN_COUNT < 32) ? PIN_COUNT : 32;

  geiq_pkg::cfg_t      cfg;
  geiq_pkg::cls_item_t cls_in;
  geiq_pkg::cls_item_t cls_out;
  geiq_pkg::out_item_t back_res;
  logic                mid_empty;
  logic                out_full;
  logic                go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.global_enable   <= 1'b1;
      cfg.pin_enable_mask <= '0;
      cfg.rising_mask     <= '0;
      cfg.falling_mask    <= '0;
      cfg.debounce_ms     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        geiq_pkg::CFG_GLOBAL_ENABLE:   cfg.global_enable   <= cfg_data[0];
        geiq_pkg::CFG_PIN_ENABLE_MASK: cfg.pin_enable_mask <= cfg_data;
        geiq_pkg::CFG_RISING_MASK:     cfg.rising_mask     <= cfg_data;
        geiq_pkg::CFG_FALLING_MASK:    cfg.falling_mask    <= cfg_data;
        geiq_pkg::CFG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data[geiq_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  geiq_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .cfg (cfg),
    .evt (evt),
    .cls (cls_in)
  );

  geiq_queue #(
    .item_t(geiq_pkg::cls_item_t),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cls_in),
    .full  (full),
    .pop   (go),
    .dout  (cls_out),
    .empty (mid_empty)
  );

  assign go = !mid_empty && !out_full;

  geiq_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .debounce_ms (cfg.debounce_ms),
    .cls         (cls_out),
    .res         (back_res)
  );

  geiq_queue #(
    .item_t(geiq_pkg::out_item_t),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (go),
    .din   (back_res),
    .full  (out_full),
    .pop   (pop),
    .dout  (res),
    .empty (empty)
  );

endmodule
